[hdl/fbip_pkg.sv]
`timescale 1ns / 1ps

package fbip_pkg;

	localparam int unsigned MAX_CHARS_NARROW = 6;
	localparam int unsigned MAX_CHARS_WIDE   = 12;
	localparam int unsigned SLOT_LIMIT       = 12;

	localparam int unsigned CODE_W  = 5;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned COUNT_W = 4;

	localparam logic [3:0] LIMIT_NARROW = 4'(MAX_CHARS_NARROW);
	localparam logic [3:0] LIMIT_WIDE   = 4'(MAX_CHARS_WIDE);

	// 5-bit code in the low bits, bit 5 flags a byte outside the alphabet
	typedef logic [CODE_W:0] lookup_t;

	localparam lookup_t CODE_NUL = 6'h00;
	localparam lookup_t CODE_BAD = 6'h20;

	function automatic lookup_t code_of(input logic [7:0] b);
		lookup_t c;
		case (b)
			8'h00:   c = CODE_NUL;
			"." :    c = 6'd1;
			"0" :    c = 6'd2;
			"1" :    c = 6'd3;
			"2" :    c = 6'd4;
			"A" :    c = 6'd5;
			"C" :    c = 6'd6;
			"E" :    c = 6'd7;
			"I" :    c = 6'd8;
			"L" :    c = 6'd9;
			"M" :    c = 6'd10;
			"P" :    c = 6'd11;
			"R" :    c = 6'd12;
			"S" :    c = 6'd13;
			"T" :    c = 6'd14;
			"_" :    c = 6'd15;
			"a" :    c = 6'd16;
			"b" :    c = 6'd17;
			"c" :    c = 6'd18;
			"d" :    c = 6'd19;
			"e" :    c = 6'd20;
			"g" :    c = 6'd21;
			"i" :    c = 6'd22;
			"l" :    c = 6'd23;
			"m" :    c = 6'd24;
			"n" :    c = 6'd25;
			"o" :    c = 6'd26;
			"p" :    c = 6'd27;
			"r" :    c = 6'd28;
			"s" :    c = 6'd29;
			"t" :    c = 6'd30;
			"u" :    c = 6'd31;
			default: c = CODE_BAD;
		endcase
		return c;
	endfunction

endpackage

[hdl/fbip_if.sv]
`timescale 1ns / 1ps

interface fbip_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_byte;

	modport source (output valid, output char_byte, output last_byte, input ready);
	modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface fbip_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] packed_word;
	logic        is_valid;
	logic [3:0]  packed_count;

	modport source (output valid, output packed_word, output is_valid, output packed_count,
		input ready);
	modport sink   (input valid, input packed_word, input is_valid, input packed_count,
		output ready);
endinterface

interface fbip_cfg_if;
	logic valid;
	logic ready;
	logic wide_mode;

	modport source (output valid, output wide_mode, input ready);
	modport sink   (input valid, input wide_mode, output ready);
endinterface

[hdl/five_bit_identifier_packer.sv]
`timescale 1ns / 1ps

// Channel  Dir  Payload                                  Beat
// -------  ---  ---------------------------------------  -----------------------------
// chars    in   char_byte[7:0], last_byte                one identifier byte
// result   out  packed_word[63:0], is_valid, packed_count one packed identifier
// cfg      in   wide_mode                                register write, always ready
//
// One byte beat per cycle while no last byte stalls: lookup, limit check and slot insert all
// sit between the beat and the per-identifier state registers.
// A last byte loads the result register; the word shows on the result port from the next cycle.
// arst_n clears the identifier state and the result valid; wide_mode resets to 1.
// Non-last bytes keep flowing while a result waits; only a last byte stalls,
// and only while the result register is full and not being drained.

module five_bit_identifier_packer
	import fbip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fbip_byte_if.sink   chars,
	fbip_word_if.source result,
	fbip_cfg_if.sink    cfg
);

	// Configuration
	logic wide_q;

	// Per-identifier state
	logic [WORD_W-1:0]  acc_q;
	logic [COUNT_W-1:0] slot_q;
	logic [3:0]         total_q;
	logic               term_q;
	logic               fault_q;

	// Result register
	logic               res_valid_q;
	logic [WORD_W-1:0]  res_word_q;
	logic               res_ok_q;
	logic [COUNT_W-1:0] res_count_q;

	// Next-state terms
	logic               accept;
	logic [3:0]         limit;
	logic [4:0]         total_inc;
	logic [3:0]         total_n;
	logic               fault_n;
	logic               term_n;
	logic [WORD_W-1:0]  acc_n;
	logic [COUNT_W-1:0] slot_n;
	lookup_t            code;

	assign cfg.ready = 1'b1;

	// A last byte needs room in the result register; other bytes never wait.
	assign chars.ready = !res_valid_q || result.ready || !chars.last_byte;
	assign accept      = chars.valid && chars.ready;

	assign code  = code_of(chars.char_byte);
	assign limit = wide_q ? LIMIT_WIDE : LIMIT_NARROW;

	always_comb begin
		// Count every byte, NULs too, saturating one past the limit of the current mode.
		total_inc = {1'b0, total_q} + 5'd1;
		if (total_inc > {1'b0, limit} + 5'd1) begin
			total_n = limit + 4'd1;
		end else begin
			total_n = total_inc[3:0];
		end
		fault_n = fault_q || (total_n > limit);
		term_n  = term_q;
		acc_n   = acc_q;
		slot_n  = slot_q;

		if (!term_q && !fault_n) begin
			if (code == CODE_NUL) begin
				term_n = 1'b1;
			end else if (code[CODE_W] || (slot_q >= COUNT_W'(SLOT_LIMIT))) begin
				fault_n = 1'b1;
			end else begin
				// Drop the code into the slot picked by slot_q.
				for (int i = 0; i < SLOT_LIMIT; i++) begin
					if (slot_q == COUNT_W'(i)) begin
						acc_n[i*CODE_W +: CODE_W] = acc_q[i*CODE_W +: CODE_W] | code[CODE_W-1:0];
					end
				end
				slot_n = slot_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			wide_q <= cfg.wide_mode;
		end
	end

	// Advance the identifier state; clear it once the last byte has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			slot_q  <= '0;
			total_q <= '0;
			term_q  <= 1'b0;
			fault_q <= 1'b0;
		end else if (accept) begin
			if (chars.last_byte) begin
				acc_q   <= '0;
				slot_q  <= '0;
				total_q <= '0;
				term_q  <= 1'b0;
				fault_q <= 1'b0;
			end else begin
				acc_q   <= acc_n;
				slot_q  <= slot_n;
				total_q <= total_n;
				term_q  <= term_n;
				fault_q <= fault_n;
			end
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && chars.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chars.last_byte) begin
			res_word_q  <= fault_n ? '0 : acc_n;
			res_ok_q    <= !fault_n;
			res_count_q <= fault_n ? '0 : slot_n;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.packed_word  = res_word_q;
	assign result.is_valid     = res_ok_q;
	assign result.packed_count = res_count_q;

`ifndef SYNTHESIS
	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chars.last_byte |=> res_valid_q)
		else $error("last byte beat did not load the result register");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ok_q |-> (res_word_q == '0) && (res_count_q == '0))
		else $error("rejected identifier carries a nonzero word or count");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= COUNT_W'(SLOT_LIMIT) && total_q <= LIMIT_WIDE + 4'd1)
		else $error("slot or byte count beyond its bound");

	a_top_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_word_q[WORD_W-1:SLOT_LIMIT*CODE_W] == '0))
		else $error("packed word has bits above the last slot");
`endif

endmodule
